FILE: hw/rtl/tbtg_pkg.sv
// Shared constants, types and status codes of the timed beep tone generator.
package tbtg_pkg;

    localparam int unsigned TICK_MS     = 10;
    localparam int unsigned DATA_W      = 16;
    // 1000 times the tick length in ms; dividend of the half-period division
    localparam int unsigned NUMER       = 1000 * TICK_MS;
    localparam int unsigned NUMER_W     = $clog2(NUMER + 1);
    localparam int unsigned DIV_W       = (NUMER_W > DATA_W) ? NUMER_W : DATA_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);

    // duration / TICK_MS as multiply by reciprocal, exact for all 16-bit inputs
    localparam int unsigned TICK_LOG    = $clog2(TICK_MS);
    localparam int unsigned RECIP_SHIFT = DATA_W + TICK_LOG;
    localparam int unsigned RECIP_W     = DATA_W + 1;
    localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + TICK_MS - 1) / TICK_MS;
    localparam int unsigned PROD_W      = DATA_W + RECIP_W;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [DIV_W-1:0]  t_div_word;
    typedef logic [1:0]        t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_BUSY    = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

endpackage

FILE: hw/rtl/timed_beep_tone_generator.sv
// Timed beep tone generator: buzzer square wave with a duration, timer tick driven.
//
// Input channel s_axis: tuser carries the item kind (0 = one timer tick elapsed,
// 1 = beep request); tdata carries tone_freq and duration_ms, used by beeps only.
// Output channel m_axis: one result item per input item, in order, giving the
// buzzer pin level, a status (ok / busy refused / invalid frequency refused)
// and whether a countdown is armed.
// A tick passes through S_DONE into the output register, and the input is ready
// again once the result is written. An accepted beep runs the half-period
// 1000*TICK_MS/tone_freq and the toggle count (duration_ms/TICK_MS)/period one
// after the other on a single bit-serial divider. A beep refused as busy or for
// zero frequency goes straight to S_DONE; one refused for a zero period runs
// only the first division. The input is not ready meanwhile.
// The result sits in an output register, so one further item is taken while a
// result waits; when the receiver stalls, the block then holds until the
// result register frees up.
// Reset (synchronous, active low) disarms the countdown, clears period and
// toggle count and drives the pin high, as at power-up initialization.
module timed_beep_tone_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [15:0] tone_freq, [31:16] duration_ms
    input  logic        i_s_axis_tuser,  // [0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // [0] pin_level, [2:1] status, [3] active
);
    import tbtg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV1 = 2'd1;  // half-period division
    localparam logic [1:0] S_DIV2 = 2'd2;  // toggle count division
    localparam logic [1:0] S_DONE = 2'd3;  // result waits for the output register

    logic [1:0] r_state;

    // tone state
    t_word      r_period;
    t_word      r_toggles;
    t_word      r_countdown;
    logic       r_armed;
    logic       r_pin;

    // per-item work registers
    t_status    r_res_status;
    t_word      r_dur_ticks;
    t_word      r_new_period;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    t_word      w_freq;
    t_word      w_dur;
    logic       w_accept;
    logic       w_beep_go;
    logic       w_out_free;
    logic [PROD_W-1:0] w_dur_prod;
    t_word      w_quo16;

    logic       w_div_start;
    t_div_word  w_div_dividend;
    t_word      w_div_divisor;
    logic       w_div_busy;
    logic       w_div_done;
    t_div_word  w_div_quo;

    assign w_freq     = i_s_axis_tdata[15:0];
    assign w_dur      = i_s_axis_tdata[31:16];
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_beep_go  = i_s_axis_tuser && (r_toggles == '0) && (w_freq != '0);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    // duration in ticks, via reciprocal multiply, registered at acceptance
    assign w_dur_prod = PROD_W'(w_dur) * PROD_W'(RECIP);
    // period is taken modulo 2^16
    assign w_quo16    = w_div_quo[DATA_W-1:0];

    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = DIV_W'(NUMER);
        w_div_divisor  = w_freq;
        if (r_state == S_IDLE) begin
            w_div_start = w_accept && w_beep_go;
        end else if (r_state == S_DIV1) begin
            w_div_start    = w_div_done && (w_quo16 != '0);
            w_div_dividend = DIV_W'(r_dur_ticks);
            w_div_divisor  = w_quo16;
        end
    end

    tbtg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= '0;
            r_toggles   <= '0;
            r_countdown <= '0;
            r_armed     <= 1'b0;
            r_pin       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // a new result takes precedence over the drain of the old one
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_s_axis_tuser) begin
                            // timer tick
                            if (r_armed) begin
                                if (r_countdown > t_word'(1)) begin
                                    r_countdown <= r_countdown - 1'b1;
                                end else if (r_toggles == '0) begin
                                    r_countdown <= '0;
                                    r_pin       <= 1'b0;
                                    r_armed     <= 1'b0;
                                end else begin
                                    r_toggles   <= r_toggles - 1'b1;
                                    r_pin       <= ~r_pin;
                                    r_countdown <= r_period;
                                end
                            end
                            r_state <= S_DONE;
                        end else if (w_beep_go) begin
                            r_state <= S_DIV1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= (w_quo16 != '0) ? S_DIV2 : S_DONE;
                    end
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_pin       <= 1'b1;
                        r_period    <= r_new_period;
                        r_toggles   <= w_quo16;
                        r_countdown <= r_new_period;
                        r_armed     <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_dur_ticks <= w_dur_prod[RECIP_SHIFT +: DATA_W];
            if (!i_s_axis_tuser) begin
                r_res_status <= ST_OK;
            end else if (r_toggles != '0) begin
                r_res_status <= ST_BUSY;
            end else if (w_freq == '0) begin
                r_res_status <= ST_INVALID;
            end else begin
                r_res_status <= ST_OK;
            end
        end
        if (r_state == S_DIV1 && w_div_done) begin
            r_new_period <= w_quo16;
            if (w_quo16 == '0) begin
                r_res_status <= ST_INVALID;
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= {4'b0000, r_armed, r_res_status, r_pin};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_div_busy)
        else $error("input ready while divider busy");

    a_armed_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_period != '0))
        else $error("armed with zero period");

    a_toggles_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_toggles != '0) |-> r_armed)
        else $error("toggles pending while disarmed");

    a_disarmed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_countdown == '0))
        else $error("countdown left while disarmed");
`endif

endmodule

FILE: hw/rtl/tbtg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module tbtg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tbtg_pkg::t_div_word i_dividend,
    input  tbtg_pkg::t_word     i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output tbtg_pkg::t_div_word o_quotient
);
    import tbtg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_word                r_rem;
    t_div_word            r_quo;
    t_word                r_div;

    logic [DATA_W:0]      w_trial;
    logic [DATA_W:0]      w_diff;
    logic                 w_fit;
    t_word                n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses right after the last quotient bit
            r_done <= r_busy && (r_cnt == '0);
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
